/* src/sust_pkg.sv */
// shared constants for the sorted unique set table
`default_nettype none
package sust_pkg;

	localparam int CAPACITY_DEFAULT = 128;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 8;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 8;
	localparam int ELEM_W  = 8;

	// stream words padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 8'd100;

endpackage
`default_nettype wire

/* src/sust_ram.sv */
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none
module sust_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/sorted_unique_set_table.sv */
// sorted unique set table: ascending set of distinct values kept in one ram
//
// channel   dir  handshake                  payload (low bit first)
// s_*       in   s_tvalid / s_tready        operation[1:0] value[9:2] position[16:10]
// m_*       out  m_tvalid / m_tready        ok[0] count[8:1] element[16:9]
// cfg_*     in   cfg_wen                    max_value[7:0]
//
// one item at a time, paced by the entry ram
// read: one ram read; rejected at start: insert above max_value or when full, read past the count
// search compares entries from the bottom; insert or remove then moves entries one at a time
// reset clears the count and max_value to 100; ram contents are left as they are
// a result waits in the output register; the sequencer holds at its last step
// only while that register is still full
`default_nettype none
module sorted_unique_set_table #(
	parameter int CAPACITY = sust_pkg::CAPACITY_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// operation[1:0], value[9:2], position[16:10], zero fill
	input  wire logic [sust_pkg::IN_TDATA_W-1:0]    s_tdata,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// ok[0], count[8:1], element[16:9], zero fill
	output      logic [sust_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire logic                               cfg_wen,
	input  wire logic [sust_pkg::VALUE_W-1:0]       cfg_wdata
);
	import sust_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_SRCH_RD  = 4'd2;
	localparam logic [3:0] S_SRCH_CHK = 4'd3;
	localparam logic [3:0] S_INS_RD   = 4'd4;
	localparam logic [3:0] S_INS_WR   = 4'd5;
	localparam logic [3:0] S_REM_RD   = 4'd6;
	localparam logic [3:0] S_REM_WR   = 4'd7;
	localparam logic [3:0] S_READ     = 4'd8;

	logic [3:0]         state_q, state_d;
	logic [OP_W-1:0]    op_q;
	logic [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      idx_q, idx_d;
	logic [CW-1:0]      point_q, point_d;
	logic [CW-1:0]      count_q, count_d;
	logic [VALUE_W-1:0] max_value_q;

	logic               out_valid_q;
	logic               ok_q;
	logic [COUNT_W-1:0] count_out_q;
	logic [ELEM_W-1:0]  elem_q;

	logic               out_free;
	logic               finish;
	logic               fin_ok;
	logic [ELEM_W-1:0]  fin_elem;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	sust_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		point_d   = point_q;
		count_d   = count_q;
		finish    = 1'b0;
		fin_ok    = 1'b0;
		fin_elem  = '0;
		ram_we    = 1'b0;
		ram_waddr = AW'(idx_q);
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = AW'(idx_q);

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				idx_d = '0;
				case (op_q)
					OP_INSERT: begin
						if (val_q > max_value_q || count_q >= CAP_C) begin
							finish = out_free;
						end else begin
							state_d = S_SRCH_RD;
						end
					end
					OP_REMOVE: begin
						state_d = S_SRCH_RD;
					end
					OP_READ: begin
						if (PW'(pos_q) < PW'(count_q)) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(pos_q);
							state_d   = S_READ;
						end else begin
							finish = out_free;
						end
					end
					default: begin
						finish = out_free;
					end
				endcase
			end
			S_SRCH_RD: begin
				if (idx_q == count_q) begin
					// ran off the end: insert goes at the top, remove misses
					if (op_q == OP_INSERT) begin
						point_d = count_q;
						idx_d   = count_q;
						state_d = S_INS_RD;
					end else begin
						finish = out_free;
					end
				end else begin
					ram_re  = 1'b1;
					state_d = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (ram_rdata == val_q) begin
					if (op_q == OP_INSERT) begin
						finish = out_free;
					end else begin
						state_d = S_REM_RD;
					end
				end else if (ram_rdata > val_q) begin
					if (op_q == OP_INSERT) begin
						point_d = idx_q;
						idx_d   = count_q;
						state_d = S_INS_RD;
					end else begin
						finish = out_free;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_SRCH_RD;
				end
			end
			S_INS_RD: begin
				if (idx_q == point_q) begin
					if (out_free) begin
						ram_we    = 1'b1;
						ram_wdata = val_q;
						count_d   = count_q + 1'b1;
						finish    = 1'b1;
						fin_ok    = 1'b1;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q - 1'b1);
					state_d   = S_INS_WR;
				end
			end
			S_INS_WR: begin
				// move one entry up
				ram_we  = 1'b1;
				idx_d   = idx_q - 1'b1;
				state_d = S_INS_RD;
			end
			S_REM_RD: begin
				if (idx_q + 1'b1 == count_q) begin
					if (out_free) begin
						count_d = count_q - 1'b1;
						finish  = 1'b1;
						fin_ok  = 1'b1;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = AW'(idx_q + 1'b1);
					state_d   = S_REM_WR;
				end
			end
			S_REM_WR: begin
				// move one entry down over the gap
				ram_we  = 1'b1;
				idx_d   = idx_q + 1'b1;
				state_d = S_REM_RD;
			end
			S_READ: begin
				finish   = out_free;
				fin_ok   = 1'b1;
				fin_elem = ram_rdata;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (finish) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			max_value_q <= MAX_VALUE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wen) begin
				max_value_q <= cfg_wdata;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		point_q <= point_d;
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[1:0];
			val_q <= s_tdata[9:2];
			pos_q <= s_tdata[16:10];
		end
		if (finish) begin
			ok_q        <= fin_ok;
			count_out_q <= COUNT_W'(count_d);
			elem_q      <= fin_ok ? fin_elem : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, elem_q, count_out_q, ok_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("stored count exceeds capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ram_we)
		else $error("ram written while idle");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> idx_q <= count_q)
		else $error("ram write beyond stored entries");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_RD && idx_q == point_q && out_free)
			|=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance count");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> out_free)
		else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire
